// ===== hdl/eppq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// eppq_pkg
// Shared types and constants for the e-paper plane quantizer and packer.
// ---------------------------------------------------------------------------
package eppq_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned LumaW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgValW = 8;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned CodeW   = 2;

  // Plane selection
  typedef enum logic [1:0] {
    PLANE_GREY   = 2'd0,
    PLANE_RED    = 2'd1,
    PLANE_YELLOW = 2'd2,
    PLANE_MONO   = 2'd3
  } plane_mode_e;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegPlaneMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMonoInvert = 2'd1;

  // Grey thresholds
  localparam logic [ChanW-1:0] GreyHi = 8'd171;
  localparam logic [ChanW-1:0] GreyLo = 8'd85;
  // Red plane thresholds
  localparam logic [ChanW-1:0] RedRMin  = 8'd171;
  localparam logic [ChanW-1:0] RedGbMax = 8'd110;
  // Yellow plane thresholds
  localparam logic [ChanW-1:0] YelRMin = 8'd228;
  localparam logic [ChanW-1:0] YelGMin = 8'd180;
  localparam logic [ChanW-1:0] YelBMax = 8'd30;

  // Luma weights, scale 1/256 (0.21, 0.72, 0.07), threshold 127*256
  localparam logic [ChanW-1:0] LumaKr     = 8'd54;
  localparam logic [ChanW-1:0] LumaKg     = 8'd184;
  localparam logic [ChanW-1:0] LumaKb     = 8'd18;
  localparam logic [LumaW-1:0] LumaThresh = 16'd32512;

  // Grey codes
  localparam logic [CodeW-1:0] GreyWhite = 2'b00;
  localparam logic [CodeW-1:0] GreyMid   = 2'b01;
  localparam logic [CodeW-1:0] GreyBlack = 2'b11;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             row_last;
  } pix_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       row_end;
  } pbyte_t;

endpackage

`default_nettype wire

// ===== hdl/epaper_plane_quantize_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// epaper_plane_quantize_pack
// RGB pixel stream to packed e-paper plane bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one RGB pixel
//   per transfer plus row_last. Output channel (out_valid_o / out_stall_i /
//   out_data_o) carries one packed byte per transfer with row_end.
//   Config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0 is
//   plane_mode, index 1 is mono_invert, other indexes are dropped. Write it
//   only while the pipe is empty.
//   Pipeline: input register, then classify + pack into the output register.
//   A pixel that completes a byte (4 in grey, 8 in 1 bpp modes) or carries
//   row_last passes the input register and then loads the output register.
//   Throughput is one pixel per cycle while no emitting pixel is blocked.
//   Back pressure: while the output byte is held by out_stall_i the input
//   register may still advance pixels that complete no byte; a pixel that
//   would emit waits, and in_stall_o rises once it is blocked.
//   Reset clears both valid flags, the accumulator, the slot count and the
//   config registers (grey mode, no inversion).
// ---------------------------------------------------------------------------
module epaper_plane_quantize_pack (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire eppq_pkg::pix_t                 in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output eppq_pkg::pbyte_t                    out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [eppq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [eppq_pkg::CfgValW-1:0]   cfg_value_i
);
  import eppq_pkg::*;

  // Configuration registers
  plane_mode_e mode_q;
  logic        invert_q;

  // Input register
  logic s1_valid_q;
  pix_t s1_pix_q;

  // Packing state
  logic [7:0]       acc_q, acc_d;
  logic [SlotW-1:0] cnt_q, cnt_d;

  // Output register
  logic   out_valid_q;
  pbyte_t out_q;

  logic             s1_adv, in_take, out_take;
  logic [CodeW-1:0] code;
  logic [7:0]       ins, acc_new;
  logic [2:0]       shamt;
  logic             full, emit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= PLANE_GREY;
      invert_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPlaneMode:  mode_q   <= plane_mode_e'(cfg_value_i[1:0]);
        RegMonoInvert: invert_q <= cfg_value_i[0];
        default: ;
      endcase
    end
  end

  eppq_classify u_classify (
    .pix_i    (s1_pix_q),
    .mode_i   (mode_q),
    .invert_i (invert_q),
    .code_o   (code)
  );

  // Slot placement: grey uses slot cnt mod 4 at 2 bits, 1 bpp uses cnt directly
  always_comb begin
    if (mode_q == PLANE_GREY) begin
      shamt = {~cnt_q[1:0], 1'b0};
      full  = (cnt_q >= 3'd3);
    end else begin
      shamt = 3'd7 - cnt_q;
      full  = (cnt_q == 3'd7);
    end
  end

  assign ins     = 8'(code) << shamt;
  assign acc_new = acc_q | ins;
  assign emit    = full || s1_pix_q.row_last;

  // Pixel leaves the input register when it emits nothing or the output slot frees
  assign out_take   = out_valid_q && !out_stall_i;
  assign s1_adv     = s1_valid_q && (!emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (s1_adv) begin
      acc_d = emit ? 8'd0 : acc_new;
      cnt_d = emit ? '0 : cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= 8'd0;
      cnt_q       <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (in_take)     s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv && emit) out_valid_q <= 1'b1;
      else if (out_take)  out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) s1_pix_q <= in_data_i;
    if (s1_adv && emit) begin
      out_q.packed_byte <= acc_new;
      out_q.row_end     <= s1_pix_q.row_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/eppq_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// eppq_classify
// Maps one pixel to its plane code: 2 bits in grey mode, else 1 bit in LSB.
// ---------------------------------------------------------------------------
module eppq_classify (
  input  wire eppq_pkg::pix_t                  pix_i,
  input  wire eppq_pkg::plane_mode_e           mode_i,
  input  wire logic                            invert_i,
  output logic [eppq_pkg::CodeW-1:0]           code_o
);
  import eppq_pkg::*;

  logic [ChanW-1:0] r, g, b;
  logic [LumaW-1:0] luma;
  logic             is_red, is_white, is_mid;

  assign r = pix_i.red;
  assign g = pix_i.green;
  assign b = pix_i.blue;

  assign luma = LumaW'(r) * LumaW'(LumaKr)
              + LumaW'(g) * LumaW'(LumaKg)
              + LumaW'(b) * LumaW'(LumaKb);

  assign is_red   = (r > GreyHi) && (g < GreyLo) && (b < GreyLo);
  assign is_white = (r > GreyHi) && (g > GreyHi) && (b > GreyHi);
  assign is_mid   = (r > GreyLo) && (r < GreyHi) && (g > GreyLo) && (g < GreyHi)
                 && (b > GreyLo) && (b < GreyHi);

  always_comb begin
    case (mode_i)
      PLANE_GREY: begin
        if (is_red || is_white) code_o = GreyWhite;
        else if (is_mid)        code_o = GreyMid;
        else                    code_o = GreyBlack;
      end
      PLANE_RED:
        code_o = {1'b0, (r > RedRMin) && (g < RedGbMax) && (b < RedGbMax)};
      PLANE_YELLOW:
        code_o = {1'b0, (r > YelRMin) && (g > YelGMin) && (b < YelBMax)};
      PLANE_MONO:
        code_o = {1'b0, (luma < LumaThresh) ^ invert_i};
      default:
        code_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/eppq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// eppq_checker
// Port-level checks for the plane quantizer and packer, bound to the top.
// ---------------------------------------------------------------------------
module eppq_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire eppq_pkg::pbyte_t  out_data_o
);

  // Held byte stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output byte changed while stalled");

  // Input is only held back by a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  // A fresh byte must trace back to an earlier pixel transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output byte without a matching input transfer");

  // Empty output never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind epaper_plane_quantize_pack eppq_checker u_eppq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
